>>> rtl/cwa_pkg.sv
// Shared types for the centered window average core: item payloads,
// controller states and the command and status groups between the parts.
// No dependencies.
package cwa_pkg;

   // Width of one sample and of one average.
   localparam int SAMPLE_W = 16;

   // One input item.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                end_of_block;
   } req_payload_type;

   // One result item.
   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic                last_out;
   } rsp_payload_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEND,
      ST_SHIFT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic shift_in;
      logic shift_zero;
      logic load_product;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic flushing;
      logic flush_done;
   } status_type;

endpackage

>>> rtl/centered_window_average_core.sv
// Top level of the centered window average core: controller plus datapath.
// Depends on cwa_pkg, cwa_ctrl and cwa_datapath.
//
// For each sample j of a block this core delivers the sum of samples
// j-HALF_WIDTH..j+HALF_WIDTH (positions outside the block count as zero),
// divided by 2*HALF_WIDTH+1 and truncated. Output j appears after sample
// j+HALF_WIDTH is taken; the sample marked end_of_block starts a flush that
// delivers the remaining outputs, the final one marked last_out, and then
// clears all state. Items are handled one at a time: a sample that owes no
// output passes through intake and evaluation, one that owes an output also
// waits in delivery while rsp_stall holds the result, and the end-of-block
// flush adds HALF_WIDTH window steps, each a zero shift, an evaluation and,
// where owed, a delivery. The quotient is formed by a registered multiply by
// the reciprocal of the window length.
module centered_window_average_core #(
   parameter int HALF_WIDTH = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cwa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cwa_pkg::rsp_payload_type rsp_payload
);

   cwa_pkg::cmd_type    cmd;
   cwa_pkg::status_type status;

   cwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cwa_datapath #(
      .HALF_WIDTH (HALF_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/cwa_datapath.sv
// Datapath of the centered window average core: sample window, running sum,
// counters and the reciprocal divider with its result register.
// Depends on cwa_pkg.
module cwa_datapath #(
   parameter int HALF_WIDTH = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cwa_pkg::cmd_type         cmd,
   input  cwa_pkg::req_payload_type req_payload,
   output cwa_pkg::status_type      status,
   output cwa_pkg::rsp_payload_type rsp_payload
);

   localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
   localparam int SUM_W   = cwa_pkg::SAMPLE_W + $clog2(WIN_LEN);
   localparam int CNT_W   = $clog2(HALF_WIDTH + 2);
   // Rounded-up reciprocal that gives an exact floor for every sum below 2**SUM_W.
   localparam int SHIFT_S  = SUM_W + $clog2(WIN_LEN);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((longint'(1) << SHIFT_S) + longint'(WIN_LEN) - 1) / longint'(WIN_LEN);

   logic [cwa_pkg::SAMPLE_W-1:0] win_ff [WIN_LEN];
   logic [cwa_pkg::SAMPLE_W-1:0] win_in [WIN_LEN];
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             seen_ff, seen_in;
   logic [CNT_W-1:0]             flush_ff, flush_in;
   logic                         eob_ff, eob_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic                         last_ff, last_in;
   logic [RECIP_W-1:0]           recip;
   logic [CNT_W-1:0]             remaining;
   logic [CNT_W:0]               flush_reach;
   logic [cwa_pkg::SAMPLE_W-1:0] new_sample;
   logic                         shifting;

   assign recip = RECIP_W'(RECIP_VAL);

   // Window shift, running sum and block counters.
   always_comb begin
      shifting   = cmd.shift_in | cmd.shift_zero;
      new_sample = cmd.shift_in ? req_payload.sample : '0;
      win_in     = win_ff;
      sum_in     = sum_ff;
      seen_in    = seen_ff;
      flush_in   = flush_ff;
      eob_in     = eob_ff;
      if (cmd.clear) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            win_in[i] = '0;
         end
         sum_in   = '0;
         seen_in  = '0;
         flush_in = '0;
         eob_in   = 1'b0;
      end else if (shifting) begin
         for (int i = 1; i < WIN_LEN; i++) begin
            win_in[i] = win_ff[i-1];
         end
         win_in[0] = new_sample;
         sum_in    = sum_ff + SUM_W'(new_sample) - SUM_W'(win_ff[WIN_LEN-1]);
         if (cmd.shift_in) begin
            eob_in = req_payload.end_of_block;
            if (seen_ff != CNT_W'(HALF_WIDTH + 1)) begin
               seen_in = seen_ff + 1'b1;
            end
         end else begin
            flush_in = flush_ff + 1'b1;
         end
      end
   end

   // Whether the window now centers on a sample that owes an output.
   always_comb begin
      remaining   = (seen_ff < CNT_W'(HALF_WIDTH)) ? seen_ff : CNT_W'(HALF_WIDTH);
      flush_reach = {1'b0, flush_ff} + {1'b0, remaining};
      if (flush_ff == '0) begin
         status.emit = (seen_ff == CNT_W'(HALF_WIDTH + 1));
      end else begin
         status.emit = (flush_reach > (CNT_W + 1)'(HALF_WIDTH));
      end
      status.flushing   = eob_ff;
      status.flush_done = (flush_ff == CNT_W'(HALF_WIDTH));
   end

   // Product with the reciprocal; the quotient is its upper bits.
   always_comb begin
      prod_in = prod_ff;
      last_in = last_ff;
      if (cmd.load_product) begin
         prod_in = PROD_W'(sum_ff) * PROD_W'(recip);
         last_in = status.flush_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff   <= '0;
         seen_ff  <= '0;
         flush_ff <= '0;
         eob_ff   <= 1'b0;
      end else begin
         win_ff   <= win_in;
         sum_ff   <= sum_in;
         seen_ff  <= seen_in;
         flush_ff <= flush_in;
         eob_ff   <= eob_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      last_ff <= last_in;
   end

   assign rsp_payload.average  = prod_ff[SHIFT_S +: cwa_pkg::SAMPLE_W];
   assign rsp_payload.last_out = last_ff;

   // The sample count saturates one past the half width.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(HALF_WIDTH + 1))
      else $error("sample count passed its saturation value");

   // A marked output only comes from the flush of a marked block.
   a_last_in_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.load_product && status.flush_done |-> eob_ff)
      else $error("last output loaded outside a block flush");

endmodule

>>> rtl/cwa_ctrl.sv
// Controller of the centered window average core: sequences sample intake,
// output delivery and the end-of-block flush.
// Depends on cwa_pkg.
module cwa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cwa_pkg::status_type status,
   output cwa_pkg::cmd_type    cmd
);

   cwa_pkg::ctrl_state_type state_ff, state_in;
   logic                    leaving;

   // The current position is done: no output owed, or its output was taken.
   assign leaving = ((state_ff == cwa_pkg::ST_EVAL) && !status.emit) ||
                    ((state_ff == cwa_pkg::ST_SEND) && !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cwa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cwa_pkg::ST_EVAL;
            end
         end
         cwa_pkg::ST_EVAL, cwa_pkg::ST_SEND: begin
            if ((state_ff == cwa_pkg::ST_EVAL) && status.emit) begin
               state_in = cwa_pkg::ST_SEND;
            end else if (leaving) begin
               if (status.flushing && !status.flush_done) begin
                  state_in = cwa_pkg::ST_SHIFT;
               end else begin
                  state_in = cwa_pkg::ST_IDLE;
               end
            end
         end
         cwa_pkg::ST_SHIFT: begin
            state_in = cwa_pkg::ST_EVAL;
         end
         default: begin
            state_in = cwa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_stall        = (state_ff != cwa_pkg::ST_IDLE);
      rsp_valid        = (state_ff == cwa_pkg::ST_SEND);
      cmd.shift_in     = (state_ff == cwa_pkg::ST_IDLE) && req_valid;
      cmd.shift_zero   = (state_ff == cwa_pkg::ST_SHIFT);
      cmd.load_product = (state_ff == cwa_pkg::ST_EVAL) && status.emit;
      cmd.clear        = leaving && status.flushing && status.flush_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // No item is taken while a result is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && rsp_valid))
      else $error("item accepted while a result was pending");

   // Clearing the block ends the sequence.
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (state_ff == cwa_pkg::ST_IDLE))
      else $error("controller did not return to idle after clear");

   // A result is offered only after the product was loaded.
   a_send_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_product))
      else $error("result offered without a loaded product");

endmodule

>>> verif/centered_window_average_core_tb.sv
// Self-checking testbench for centered_window_average_core: sends sample blocks,
// predicts every centered eleven-point average and compares the results.
// Depends on cwa_pkg and the centered_window_average_core RTL.
module centered_window_average_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_WIDTH = 5;
   localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
   localparam int TARGET_ITEMS = 470;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   cwa_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   cwa_pkg::rsp_payload_type rsp_payload;

   // Predicted window state.
   logic [15:0]              win_q [WIN_LEN];
   logic [19:0]              win_sum;
   int                       seen_cnt;
   cwa_pkg::rsp_payload_type avg_expected_q [$];

   int unsigned     error_count = 0;
   int unsigned     items_sent = 0;
   bit              send_quiet = 1'b0;
   bit              stall_quiet = 1'b0;

   // Long receiver hold-off, requested by a test and counted by the stall process.
   int unsigned     hold_len_req = 0;
   int unsigned     hold_req_id = 0;
   int unsigned     hold_ack_id = 0;
   int unsigned     hold_left = 0;
   int unsigned     stall_left = 0;

   centered_window_average_core #(
      .HALF_WIDTH(HALF_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < 50)
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Predictor: shift one sample into the window and keep the wide sum current.
   function automatic void window_push(logic [15:0] v);
      win_sum = win_sum + 20'(v) - 20'(win_q[WIN_LEN-1]);
      for (int i = WIN_LEN - 1; i > 0; i--) win_q[i] = win_q[i-1];
      win_q[0] = v;
   endfunction

   function automatic void clear_window();
      foreach (win_q[i]) win_q[i] = '0;
      win_sum = '0;
      seen_cnt = 0;
   endfunction

   function automatic void queue_average(bit last_flag);
      cwa_pkg::rsp_payload_type r;
      r.average = 16'(win_sum / WIN_LEN);
      r.last_out = last_flag;
      avg_expected_q.push_back(r);
   endfunction

   // Expected averages caused by one accepted sample, including the end flush.
   function automatic void predict_averages(cwa_pkg::req_payload_type item);
      int pending;
      window_push(item.sample);
      if (seen_cnt < HALF_WIDTH + 1) seen_cnt++;
      // The centered output for the sample HALF_WIDTH back is now complete.
      if (seen_cnt >= HALF_WIDTH + 1) queue_average(1'b0);
      if (item.end_of_block) begin
         // Flush the outputs still owed, feeding zeros past the block end.
         pending = (seen_cnt < HALF_WIDTH) ? seen_cnt : HALF_WIDTH;
         for (int f = 1; f <= HALF_WIDTH; f++) begin
            window_push('0);
            if (f > HALF_WIDTH - pending) queue_average(f == HALF_WIDTH);
         end
         clear_window();
      end
   endfunction

   // Send one item; valid stays high after acceptance until the next call or idle_input.
   task automatic send_item(logic [15:0] smp, logic eob);
      cwa_pkg::req_payload_type item;
      int unsigned gap;
      gap = send_quiet ? 0 : idle_len();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.sample = smp;
      item.end_of_block = eob;
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_averages(item);
      items_sent++;
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (avg_expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_block(int unsigned len);
      for (int unsigned i = 1; i <= len; i++) send_item(rand_sample(), i == len);
   endtask

   // A one-sample block gives one marked output, at full scale and at zero.
   task automatic test_single_sample();
      send_item(16'hFFFF, 1'b1);
      send_item(16'h0000, 1'b1);
      idle_input();
   endtask

   // A block shorter than the half width yields all outputs in the flush.
   task automatic test_short_block();
      send_item(16'h1234, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0001, 1'b0);
      send_item(16'h8000, 1'b1);
      idle_input();
   endtask

   // Alternating bit patterns on the sample, six samples so one output is not flushed.
   task automatic test_bit_patterns();
      for (int i = 0; i < 6; i++) send_item((i % 2) ? 16'h5555 : 16'hAAAA, i == 5);
      idle_input();
   endtask

   // Full-scale samples over a full window exercise the wide sum.
   task automatic test_wide_sum();
      for (int i = 0; i < 12; i++) send_item(16'hFFFF, i == 11);
      idle_input();
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_back_to_back();
      send_quiet = 1'b1;
      stall_quiet = 1'b1;
      send_block(10);
      send_block(10);
      idle_input();
      send_quiet = 1'b0;
      stall_quiet = 1'b0;
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_output_backpressure();
      send_quiet = 1'b1;
      hold_len_req <= 80;
      hold_req_id <= hold_req_id + 1;
      send_block(20);
      idle_input();
      send_quiet = 1'b0;
   endtask

   // The sender pauses mid-block until every expected result has come.
   task automatic test_sender_pause();
      for (int i = 0; i < 8; i++) send_item(rand_sample(), 1'b0);
      idle_input();
      wait_drained();
      repeat (20) @(posedge clock);
      for (int i = 0; i < 4; i++) send_item(rand_sample(), i == 3);
      idle_input();
   endtask

   // Random complete blocks, mostly short, some longer than a full window.
   task automatic test_random_blocks();
      int unsigned len;
      while (items_sent < TARGET_ITEMS) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
         send_block(len);
      end
      idle_input();
   endtask

   // Result stall: random idling, stretches without it, and the requested hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req_id != hold_ack_id) begin
         hold_ack_id <= hold_req_id;
         hold_left <= hold_len_req;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_len();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expected average.
   always @(posedge clock) begin : check_rsp
      cwa_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (avg_expected_q.size() == 0) begin
            report_mismatch("unexpected result, average", int'(rsp_payload.average), -1);
         end else begin
            want = avg_expected_q.pop_front();
            if (rsp_payload.average !== want.average)
               report_mismatch("average", int'(rsp_payload.average), int'(want.average));
            if (rsp_payload.last_out !== want.last_out)
               report_mismatch("last_out", int'(rsp_payload.last_out),
                               int'(want.last_out));
         end
      end
   end

   initial begin
      clear_window();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_sample();
      test_short_block();
      test_bit_patterns();
      test_wide_sum();
      test_back_to_back();
      test_output_backpressure();
      test_sender_pause();
      test_random_blocks();
      wait_drained();
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("centered_window_average_core_tb: clean");
      end else begin
         $display("centered_window_average_core_tb: errors");
      end
      $finish;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #10_000_000;
      $display("centered_window_average_core_tb: errors");
      $finish;
   end

endmodule

>>> centered_window_average_core.f
rtl/cwa_pkg.sv
rtl/cwa_datapath.sv
rtl/cwa_ctrl.sv
rtl/centered_window_average_core.sv
verif/centered_window_average_core_tb.sv
